// ===== sv/nfba_pkg.sv =====
package nfba_pkg;

  localparam int MAP_ENTRIES    = 4096;
  localparam int BLOCK_BYTES    = 4096;
  localparam int CFG_W          = 13;
  localparam int SIZE_W         = 24;
  localparam int START_W        = 12;
  localparam int OP_W           = 2;
  localparam int USABLE_RESET   = 3840;
  localparam int RESERVED_RESET = 64;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_FORMAT  = 2'd2;

  localparam logic [1:0] ENT_FREE = 2'd0;
  localparam logic [1:0] ENT_USED = 2'd1;
  localparam logic [1:0] ENT_RSVD = 2'd2;

  localparam logic CFG_USABLE   = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

endpackage

// ===== sv/next_fit_block_allocator.sv =====
// next-fit allocator of contiguous runs of blocks over a map held in one ram
// requests enter on s_tvalid/s_tready with the operation in s_tuser; one
// result per request leaves on m_tvalid/m_tready (ok in m_tuser, start in
// m_tdata). one request is worked on at a time; s_tready is high only when
// the block is idle, and a result waiting in the output register does not
// hold off the next request.
// allocate: one map read per cycle from the next-fit pointer to the usable
//   count, a second pass from 0 if needed, then n writes. a size of zero or a
//   run longer than the usable count is refused with no scan.
// release: a read-modify-write of each of the n entries, up to the map end, through the ram pipeline.
// format: one write to each of the MAP_ENTRIES entries (4096 by default).
// the map ram has one write and one registered read port; this sets the
// pace of one entry per cycle.
// reset: the map is formatted with the reset register values, with s_tready
// low until that is done; register writes are taken as ever.
// a stalled receiver only holds the result register: once it is full and
// the next result is ready, the block waits until the old one is taken.
// BLOCK_BYTES must be a power of two
module next_fit_block_allocator #(
  parameter int MAP_ENTRIES = nfba_pkg::MAP_ENTRIES,
  parameter int BLOCK_BYTES = nfba_pkg::BLOCK_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [39:0]                s_tdata,  // size_bytes[23:0], start_entry[35:24]
  input  logic [nfba_pkg::OP_W-1:0]  s_tuser,  // op
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,  // run_start[11:0]
  output logic                       m_tuser,  // ok
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [nfba_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAP_ENTRIES + 1);
  localparam int BB_SH = $clog2(BLOCK_BYTES);
  localparam int NW    = nfba_pkg::SIZE_W + 1 - BB_SH;
  localparam int MX1   = (nfba_pkg::START_W > NW) ? nfba_pkg::START_W : NW;
  localparam int REL_W = ((MX1 > CNT_W) ? MX1 : CNT_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MARK, S_REL, S_FMT, S_OUT
  } state_t;

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [nfba_pkg::CFG_W-1:0] v);
    return (32'(v) > 32'(MAP_ENTRIES)) ? CNT_W'(MAP_ENTRIES) : CNT_W'(v);
  endfunction

  state_t                       state;
  logic [nfba_pkg::CFG_W-1:0]   usable;
  logic [nfba_pkg::CFG_W-1:0]   reserved;
  logic [CNT_W-1:0]             ptr;
  logic [REL_W-1:0]             cur;
  logic [REL_W-1:0]             lim;
  logic [CNT_W-1:0]             run;
  logic [CNT_W-1:0]             n;
  logic [CNT_W-1:0]             base;
  logic [IDX_W-1:0]             rj;
  logic                         pend;
  logic                         no_wrap;
  logic                         fmt_reply;
  logic                         res_ok;
  logic [nfba_pkg::START_W-1:0] res_start;
  logic                         out_ok;
  logic [nfba_pkg::START_W-1:0] out_start;

  logic [nfba_pkg::SIZE_W-1:0]  size_bytes;
  logic [nfba_pkg::START_W-1:0] start_entry;
  logic [NW-1:0]                blocks;
  logic [CNT_W-1:0]             u_cl;
  logic [CNT_W-1:0]             rsv_cl;
  logic [CNT_W-1:0]             scan_from;
  logic [REL_W-1:0]             rel_end;
  logic [REL_W-1:0]             rel_lim;
  logic                         fits;
  logic                         issue;
  logic [CNT_W-1:0]             found_start;
  logic [CNT_W-1:0]             run_end;
  logic                         out_load;

  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  logic [1:0]                   mem_wdata;
  logic [IDX_W-1:0]             mem_raddr;
  logic [1:0]                   mem_rdata;

  assign size_bytes  = s_tdata[23:0];
  assign start_entry = s_tdata[35:24];
  assign s_tready    = (state == S_IDLE);
  assign m_tuser     = out_ok;
  assign m_tdata     = {4'd0, out_start};
  assign out_load    = (state == S_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    blocks      = NW'(({1'b0, size_bytes} + 25'(BLOCK_BYTES - 1)) >> BB_SH);
    u_cl        = clamp_cnt(usable);
    rsv_cl      = clamp_cnt(reserved);
    scan_from   = (ptr < u_cl) ? ptr : '0;
    fits        = (blocks != '0) && (u_cl != '0) && (REL_W'(blocks) <= REL_W'(u_cl));
    rel_end     = REL_W'(start_entry) + REL_W'(blocks);
    rel_lim     = (rel_end > REL_W'(MAP_ENTRIES)) ? REL_W'(MAP_ENTRIES) : rel_end;
    issue       = (cur < lim);
    found_start = CNT_W'(rj) + CNT_W'(1) - n;
    run_end     = base + n;
    mem_raddr   = IDX_W'(cur);
    mem_we      = 1'b0;
    mem_waddr   = IDX_W'(cur);
    mem_wdata   = nfba_pkg::ENT_FREE;
    case (state)
      S_FMT: begin
        mem_we    = 1'b1;
        mem_wdata = (cur < lim) ? nfba_pkg::ENT_RSVD : nfba_pkg::ENT_FREE;
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = nfba_pkg::ENT_USED;
      end
      S_REL: begin
        mem_we    = pend && (mem_rdata == nfba_pkg::ENT_USED);
        mem_waddr = rj;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FMT;
      usable    <= nfba_pkg::CFG_W'(nfba_pkg::USABLE_RESET);
      reserved  <= nfba_pkg::CFG_W'(nfba_pkg::RESERVED_RESET);
      cur       <= '0;
      lim       <= REL_W'(clamp_cnt(nfba_pkg::CFG_W'(nfba_pkg::RESERVED_RESET)));
      ptr       <= '0;
      pend      <= 1'b0;
      no_wrap   <= 1'b1;
      fmt_reply <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == nfba_pkg::CFG_USABLE) begin
          usable <= cfg_wdata;
        end else begin
          reserved <= cfg_wdata;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            pend <= 1'b0;
            case (s_tuser)
              nfba_pkg::OP_ALLOC: begin
                if (fits) begin
                  cur     <= REL_W'(scan_from);
                  lim     <= REL_W'(u_cl);
                  no_wrap <= (scan_from == '0);
                  run     <= '0;
                  n       <= CNT_W'(blocks);
                  state   <= S_SCAN;
                end else begin
                  res_ok    <= 1'b0;
                  res_start <= '0;
                  state     <= S_OUT;
                end
              end
              nfba_pkg::OP_RELEASE: begin
                cur   <= REL_W'(start_entry);
                lim   <= rel_lim;
                state <= S_REL;
              end
              nfba_pkg::OP_FORMAT: begin
                cur       <= '0;
                lim       <= REL_W'(rsv_cl);
                fmt_reply <= 1'b1;
                state     <= S_FMT;
              end
              default: begin
                res_ok    <= 1'b0;
                res_start <= '0;
                state     <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          pend <= issue;
          rj   <= IDX_W'(cur);
          if (pend && (mem_rdata == nfba_pkg::ENT_FREE) && (run + CNT_W'(1) >= n)) begin
            base  <= found_start;
            cur   <= REL_W'(found_start);
            run   <= n;
            state <= S_MARK;
          end else begin
            if (issue) begin
              cur <= cur + REL_W'(1);
            end
            if (pend) begin
              run <= (mem_rdata == nfba_pkg::ENT_FREE) ? run + CNT_W'(1) : '0;
            end else if (!issue) begin
              if (!no_wrap) begin
                cur     <= '0;
                run     <= '0;
                no_wrap <= 1'b1;
              end else begin
                res_ok    <= 1'b0;
                res_start <= '0;
                state     <= S_OUT;
              end
            end
          end
        end
        S_MARK: begin
          cur <= cur + REL_W'(1);
          run <= run - CNT_W'(1);
          if (run == CNT_W'(1)) begin
            ptr       <= (run_end == u_cl) ? '0 : run_end;
            res_ok    <= 1'b1;
            res_start <= nfba_pkg::START_W'(base);
            state     <= S_OUT;
          end
        end
        S_REL: begin
          pend <= issue;
          rj   <= IDX_W'(cur);
          if (issue) begin
            cur <= cur + REL_W'(1);
          end
          if (!pend && !issue) begin
            res_ok    <= 1'b1;
            res_start <= '0;
            state     <= S_OUT;
          end
        end
        S_FMT: begin
          cur <= cur + REL_W'(1);
          if (cur == REL_W'(MAP_ENTRIES - 1)) begin
            ptr <= CNT_W'(lim);
            if (fmt_reply) begin
              res_ok    <= 1'b1;
              res_start <= '0;
              state     <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_ok    <= res_ok;
            out_start <= res_start;
            fmt_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  nfba_map_ram #(
    .DEPTH (MAP_ENTRIES),
    .AW    (IDX_W)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== sv/nfba_map_ram.sv =====
module nfba_map_ram #(
  parameter int DEPTH = nfba_pkg::MAP_ENTRIES,
  parameter int AW    = $clog2(nfba_pkg::MAP_ENTRIES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [1:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [1:0]    rdata
);

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [nfba_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int SIZE_MAX  = (1 << nfba_pkg::SIZE_W) - 1;
  localparam int ENTRY_MAX = nfba_pkg::MAP_ENTRIES - 1;

  typedef struct {
    logic [nfba_pkg::OP_W-1:0]    op;
    logic [nfba_pkg::SIZE_W-1:0]  size_bytes;
    logic [nfba_pkg::START_W-1:0] first;
  } req_t;

  typedef struct {
    logic                         ok;
    logic [nfba_pkg::START_W-1:0] run_start;
  } grant_t;

  typedef struct {
    int first;
    int len;
  } run_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [39:0]                 s_tdata = '0;  // size_bytes[23:0], start_entry[35:24]
  logic [nfba_pkg::OP_W-1:0]   s_tuser = '0;  // op
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [15:0]                 m_tdata;       // run_start[11:0]
  logic                        m_tuser;       // ok
  logic                        cfg_we = 1'b0;
  logic                        cfg_index = 1'b0;
  logic [nfba_pkg::CFG_W-1:0]  cfg_wdata = '0;

  // model of the map
  logic [1:0] fit_map [nfba_pkg::MAP_ENTRIES];
  int         fit_ptr;
  int         usable_cfg = nfba_pkg::USABLE_RESET;
  int         reserved_cfg = nfba_pkg::RESERVED_RESET;
  run_t       live_runs[$];

  req_t   req_q[$];
  grant_t grant_q[$];

  int pushed_n, accepted_n, results_n, mismatch_n;
  int alloc_n, granted_n, release_n, format_n, other_n, reg_writes_n;
  int send_idle_max = 12, take_idle_max = 12;
  int send_wait, take_wait;

  next_fit_block_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void format_fit_map();
    int r;
    r = (reserved_cfg > nfba_pkg::MAP_ENTRIES) ? nfba_pkg::MAP_ENTRIES : reserved_cfg;
    for (int i = 0; i < nfba_pkg::MAP_ENTRIES; i++)
      fit_map[i] = (i < r) ? nfba_pkg::ENT_RSVD : nfba_pkg::ENT_FREE;
    fit_ptr = reserved_cfg;
    live_runs.delete();
  endfunction

  function automatic int seek_free_run(int from, int lim, int n);
    int run;
    run = 0;
    for (int j = from; j < lim; j++) begin
      if (fit_map[j] == nfba_pkg::ENT_FREE) begin
        run++;
        if (run >= n) return j + 1 - n;
      end else begin
        run = 0;
      end
    end
    return -1;
  endfunction

  // applies one request to the model map and gives the answer it earns
  function automatic grant_t grant_for(logic [nfba_pkg::OP_W-1:0] op,
                                       logic [nfba_pkg::SIZE_W-1:0] size,
                                       logic [nfba_pkg::START_W-1:0] first);
    grant_t g;
    int     n, u, from, pos, e;
    g.ok = 1'b0;
    g.run_start = '0;
    n = (int'(size) + nfba_pkg::BLOCK_BYTES - 1) / nfba_pkg::BLOCK_BYTES;
    case (op)
      nfba_pkg::OP_ALLOC: begin
        alloc_n++;
        u = (usable_cfg > nfba_pkg::MAP_ENTRIES) ? nfba_pkg::MAP_ENTRIES : usable_cfg;
        if (n != 0 && u != 0 && n <= u) begin
          from = (fit_ptr < u) ? fit_ptr : 0;
          pos = seek_free_run(from, u, n);
          if (pos < 0 && from != 0) pos = seek_free_run(0, u, n);
          if (pos >= 0) begin
            for (int k = 0; k < n; k++) fit_map[pos + k] = nfba_pkg::ENT_USED;
            fit_ptr = (pos + n) % u;
            g.ok = 1'b1;
            g.run_start = nfba_pkg::START_W'(pos);
            live_runs.push_back('{pos, n});
            granted_n++;
          end
        end
      end
      nfba_pkg::OP_RELEASE: begin
        release_n++;
        for (int k = 0; k < n; k++) begin
          e = int'(first) + k;
          if (e >= nfba_pkg::MAP_ENTRIES) break;
          if (fit_map[e] == nfba_pkg::ENT_USED) fit_map[e] = nfba_pkg::ENT_FREE;
        end
        g.ok = 1'b1;
      end
      nfba_pkg::OP_FORMAT: begin
        format_n++;
        format_fit_map();
        g.ok = 1'b1;
      end
      default: other_n++;
    endcase
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_n++;
    $display("mismatch on result %0d: %s is %0d, should be %0d", results_n, what, got, want);
  endtask

  // request driver
  always @(posedge clk) begin : drive
    grant_t g;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        g = grant_for(s_tuser, s_tdata[23:0], s_tdata[35:24]);
        grant_q.push_back(g);
        accepted_n++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_tvalid <= 1'b0;
        end else if (req_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tuser  <= req_q[0].op;
          s_tdata  <= {4'd0, req_q[0].first, req_q[0].size_bytes};
          void'(req_q.pop_front());
          send_wait = $urandom_range(0, send_idle_max);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : take
    grant_t want;
    if (rst) begin
      m_tready <= 1'b0;
      take_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_n++;
        if (grant_q.size() == 0) begin
          report_mismatch("result with no request waiting, run_start",
                          int'(m_tdata[11:0]), 0);
        end else begin
          want = grant_q.pop_front();
          if (m_tuser !== want.ok) report_mismatch("ok", int'(m_tuser), int'(want.ok));
          if (m_tdata[11:0] !== want.run_start)
            report_mismatch("run_start", int'(m_tdata[11:0]), int'(want.run_start));
        end
        take_wait = $urandom_range(0, take_idle_max);
      end
      if (take_wait > 0) begin
        take_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic issue(logic [nfba_pkg::OP_W-1:0] op, int size, int first);
    req_t r;
    r.op = op;
    r.size_bytes = nfba_pkg::SIZE_W'(size);
    r.first = nfba_pkg::START_W'(first);
    req_q.push_back(r);
    pushed_n++;
    while (accepted_n != pushed_n) @(negedge clk);
  endtask

  task automatic settle();
    while (accepted_n != pushed_n || grant_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[nfba_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == nfba_pkg::CFG_USABLE) usable_cfg = val & 32'h1fff;
    else reserved_cfg = val & 32'h1fff;
    reg_writes_n++;
    @(negedge clk);
  endtask

  task automatic set_regs(int usable, int reserved);
    settle();
    write_reg(nfba_pkg::CFG_USABLE, usable);
    write_reg(nfba_pkg::CFG_RESERVED, reserved);
  endtask

  task automatic issue_random();
    int   roll, n, u, idx;
    run_t r;
    u = (usable_cfg > nfba_pkg::MAP_ENTRIES) ? nfba_pkg::MAP_ENTRIES : usable_cfg;
    roll = $urandom_range(0, 99);
    if (roll < 30 && live_runs.size() != 0) begin
      idx = $urandom_range(0, live_runs.size() - 1);
      r = live_runs[idx];
      live_runs.delete(idx);
      issue(nfba_pkg::OP_RELEASE,
            (r.len - 1) * nfba_pkg::BLOCK_BYTES + $urandom_range(1, nfba_pkg::BLOCK_BYTES),
            r.first);
    end else if (roll < 37) begin
      // stray release, sometimes running off the map end
      issue(nfba_pkg::OP_RELEASE, $urandom_range(1, 6 * nfba_pkg::BLOCK_BYTES),
            ($urandom_range(0, 3) == 0) ? $urandom_range(4088, 4095) : $urandom);
    end else if (roll < 40) begin
      issue(nfba_pkg::OP_FORMAT, $urandom, $urandom);
    end else if (roll < 43) begin
      issue(OP_UNKNOWN, $urandom, $urandom);
    end else if (roll < 47) begin
      issue(nfba_pkg::OP_ALLOC,
            $urandom_range(0, 1) ? 0 : $urandom_range(u * nfba_pkg::BLOCK_BYTES + 1, SIZE_MAX),
            $urandom);
    end else begin
      n = $urandom_range(1, (u < 8) ? u : 8);
      issue(nfba_pkg::OP_ALLOC,
            (n - 1) * nfba_pkg::BLOCK_BYTES + $urandom_range(1, nfba_pkg::BLOCK_BYTES),
            $urandom);
    end
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      issue_random();
      if ($urandom_range(0, 15) == 0) settle();
    end
  endtask

  initial begin
    format_fit_map();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: edge sizes, wrap and reserved area
    issue(nfba_pkg::OP_ALLOC, 0, 0);
    issue(nfba_pkg::OP_ALLOC, 1, ENTRY_MAX);
    issue(nfba_pkg::OP_ALLOC, nfba_pkg::BLOCK_BYTES, 0);
    issue(nfba_pkg::OP_ALLOC, nfba_pkg::BLOCK_BYTES + 1, 0);
    issue(nfba_pkg::OP_ALLOC, SIZE_MAX, 0);
    issue(nfba_pkg::OP_ALLOC, 3840 * nfba_pkg::BLOCK_BYTES, 0);
    issue(nfba_pkg::OP_RELEASE, nfba_pkg::BLOCK_BYTES, 65);
    issue(nfba_pkg::OP_RELEASE, 64 * nfba_pkg::BLOCK_BYTES, 0);
    issue(nfba_pkg::OP_RELEASE, SIZE_MAX, ENTRY_MAX);
    issue(OP_UNKNOWN, SIZE_MAX, ENTRY_MAX);
    issue(nfba_pkg::OP_ALLOC, (3840 - 68) * nfba_pkg::BLOCK_BYTES, 0);
    issue(nfba_pkg::OP_ALLOC, 1, 0);
    issue(nfba_pkg::OP_ALLOC, 2 * nfba_pkg::BLOCK_BYTES, 0);
    issue(nfba_pkg::OP_FORMAT, 0, 0);

    // whole map reserved
    set_regs(nfba_pkg::MAP_ENTRIES, nfba_pkg::MAP_ENTRIES);
    issue(nfba_pkg::OP_FORMAT, SIZE_MAX, ENTRY_MAX);
    issue(nfba_pkg::OP_ALLOC, 1, 0);
    issue(nfba_pkg::OP_ALLOC, SIZE_MAX, 0);

    // usable count beyond the map, nothing reserved: run at entry 0
    set_regs(8191, 0);
    issue(nfba_pkg::OP_FORMAT, 0, 0);
    issue(nfba_pkg::OP_ALLOC, SIZE_MAX, 0);
    issue(nfba_pkg::OP_ALLOC, 1, 0);
    issue(nfba_pkg::OP_RELEASE, SIZE_MAX, 0);
    issue(nfba_pkg::OP_ALLOC, 5000, 0);

    // no usable entries, reserved count beyond the map
    set_regs(0, 5000);
    issue(nfba_pkg::OP_FORMAT, 0, 0);
    issue(nfba_pkg::OP_ALLOC, 1, 0);
    settle();
    write_reg(nfba_pkg::CFG_USABLE, 16);
    issue(nfba_pkg::OP_ALLOC, 1, 0);

    set_regs(24, 8);
    issue(nfba_pkg::OP_FORMAT, 0, 0);
    run_random(35);

    send_idle_max = 0;
    set_regs(40, 40);
    issue(nfba_pkg::OP_FORMAT, 0, 0);
    settle();
    write_reg(nfba_pkg::CFG_RESERVED, 3);
    run_random(35);

    send_idle_max = 12;
    take_idle_max = 0;
    set_regs(64, 1);
    issue(nfba_pkg::OP_FORMAT, 0, 0);
    run_random(40);

    settle();
    repeat (50) @(posedge clk);
    $display("%0d requests: %0d allocations (%0d granted), %0d releases, %0d formats, %0d other",
             accepted_n, alloc_n, granted_n, release_n, format_n, other_n);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             reg_writes_n, results_n, mismatch_n);
    if (mismatch_n == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("timeout with %0d results outstanding", grant_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/nfba_pkg.sv
sv/nfba_map_ram.sv
sv/next_fit_block_allocator.sv
dv/tb_top.sv
